// ===== hdl/base64_stream_encoder_assert.svh =====
// assertion macros for the base64 stream encoder
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// condition implies consequence in the same cycle
`define B64SE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("base64 encoder check failed");

// condition implies consequence in the next cycle
`define B64SE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("base64 encoder check failed");

`endif

// ===== hdl/b64se_pkg.sv =====
`default_nettype none
package b64se_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned SYM_W  = 6;
   localparam int unsigned COL_W  = 7;

   localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;
   localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'd65;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'd97;
   localparam logic [BYTE_W-1:0] CHAR_DIGIT_0 = 8'd48;

   localparam logic [SYM_W-1:0] SYM_LOWER_START = 6'd26;
   localparam logic [SYM_W-1:0] SYM_DIGIT_START = 6'd52;
   localparam logic [SYM_W-1:0] SYM_SIXTY_TWO   = 6'd62;

   localparam logic [COL_W-1:0] COL_MAX = 7'd127;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_CHAR_SIXTY_TWO   = 3'd0,
      REG_CHAR_SIXTY_THREE = 3'd1,
      REG_PAD_LENGTH       = 3'd2,
      REG_PAD_FIRST        = 3'd3,
      REG_PAD_SECOND       = 3'd4,
      REG_PAD_THIRD        = 3'd5,
      REG_LINE_LIMIT       = 3'd6
   } csr_reg_type;

   // map one 6-bit symbol to its output character
   function automatic logic [BYTE_W-1:0] sym_char(
      input logic [SYM_W-1:0]  sym,
      input logic [BYTE_W-1:0] c62,
      input logic [BYTE_W-1:0] c63
   );
      logic [BYTE_W-1:0] sym_ext;
      sym_ext = {2'b00, sym};
      if (sym < SYM_LOWER_START) begin
         return CHAR_UPPER_A + sym_ext;
      end else if (sym < SYM_DIGIT_START) begin
         return CHAR_LOWER_A + sym_ext - {2'b00, SYM_LOWER_START};
      end else if (sym < SYM_SIXTY_TWO) begin
         return CHAR_DIGIT_0 + sym_ext - {2'b00, SYM_DIGIT_START};
      end else if (sym == SYM_SIXTY_TWO) begin
         return c62;
      end else begin
         return c63;
      end
   endfunction

endpackage
`default_nettype wire

// ===== hdl/b64se_req_if.sv =====
`default_nettype none
interface b64se_req_if;
   import b64se_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/b64se_rsp_if.sv =====
`default_nettype none
interface b64se_rsp_if;
   import b64se_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_char;
   logic              out_last;

   modport source (output valid, output out_char, output out_last, input ready);
   modport sink   (input valid, input out_char, input out_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/base64_stream_encoder.sv =====
// base64 stream encoder: the item that closes a group is loaded into the group
// register, and its characters then leave through the result register.
// output runs at one character per cycle while the receiver is ready; a group of
// three bytes gives four characters plus any CR LF.
// items that only fill the group are taken at once unless a group is still draining.
// synchronous active-high reset restores register defaults and clears control state.
`default_nettype none
`include "base64_stream_encoder_assert.svh"
module base64_stream_encoder (
   input  wire logic                  clock,
   input  wire logic                  reset,
   b64se_req_if.sink                  req_ch,
   b64se_rsp_if.source                rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [2:0]            csr_index,
   input  wire logic [b64se_pkg::BYTE_W-1:0] csr_data
);
   import b64se_pkg::*;

   // configuration registers
   logic [BYTE_W-1:0] c62_ff, c63_ff, pad1_ff, pad2_ff, pad3_ff;
   logic [1:0]        pad_len_ff;
   logic [COL_W-1:0]  limit_ff;

   // group collection
   logic [15:0]       held_ff, held_in;
   logic [1:0]        count_ff, count_in;

   // group being emitted
   logic              job_valid_ff, job_valid_in;
   logic [23:0]       word_ff, word_in;
   logic [1:0]        sym_last_ff, sym_last_in;
   logic [1:0]        sym_idx_ff, sym_idx_in;
   logic              in_pad_ff, in_pad_in;
   logic [1:0]        pad_grp_ff, pad_grp_in;
   logic [1:0]        pad_idx_ff, pad_idx_in;
   logic              job_last_ff, job_last_in;
   logic              lf_pend_ff, lf_pend_in;
   logic [COL_W-1:0]  col_ff, col_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept, advance, step, emit_data, done;
   logic              brk_due, sym_end, no_pad, pad_end, final_ch;
   logic [SYM_W-1:0]  cur_sym;
   logic [BYTE_W-1:0] sym_ch, pad_ch, data_ch;
   logic              produce;
   logic [23:0]       new_word;
   logic [1:0]        new_sym_last, new_pad_grp;

   // handshake
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign step         = job_valid_ff && advance;
   assign req_ch.ready = !job_valid_ff || done;
   assign accept       = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_char = rsp_char_ff;
   assign rsp_ch.out_last = rsp_last_ff;

   // character selection for the current position
   always_comb begin
      case (sym_idx_ff)
         2'd0:    cur_sym = word_ff[23:18];
         2'd1:    cur_sym = word_ff[17:12];
         2'd2:    cur_sym = word_ff[11:6];
         default: cur_sym = word_ff[5:0];
      endcase
      sym_ch = sym_char(cur_sym, c62_ff, c63_ff);
      case (pad_idx_ff)
         2'd0:    pad_ch = pad1_ff;
         2'd1:    pad_ch = pad2_ff;
         default: pad_ch = pad3_ff;
      endcase
      data_ch  = in_pad_ff ? pad_ch : sym_ch;
      brk_due  = (limit_ff != '0) && (col_ff >= limit_ff);
      sym_end  = (sym_idx_ff == sym_last_ff);
      no_pad   = (pad_grp_ff == 2'd0) || (pad_len_ff == 2'd0);
      pad_end  = (pad_idx_ff == pad_len_ff - 2'd1);
      final_ch = in_pad_ff ? (pad_end && (pad_grp_ff == 2'd1)) : (sym_end && no_pad);
      emit_data = step && !lf_pend_ff && !brk_due;
      done      = emit_data && final_ch;
   end

   // group assembly from the incoming byte
   always_comb begin
      produce      = 1'b1;
      new_word     = {held_ff, req_ch.data_byte};
      new_sym_last = 2'd3;
      new_pad_grp  = 2'd0;
      held_in      = held_ff;
      count_in     = count_ff;
      if (count_ff == 2'd2) begin
         new_word = {held_ff, req_ch.data_byte};
      end else if (req_ch.last_byte) begin
         if (count_ff == 2'd1) begin
            new_word     = {held_ff[7:0], req_ch.data_byte, 8'h00};
            new_sym_last = 2'd2;
            new_pad_grp  = 2'd1;
         end else begin
            new_word     = {req_ch.data_byte, 16'h0000};
            new_sym_last = 2'd1;
            new_pad_grp  = 2'd2;
         end
      end else begin
         produce = 1'b0;
      end
      if (accept) begin
         if (produce) begin
            count_in = 2'd0;
         end else begin
            held_in  = {held_ff[7:0], req_ch.data_byte};
            count_in = count_ff + 2'd1;
         end
      end
   end

   // emitter progress and result register
   always_comb begin
      job_valid_in = job_valid_ff;
      word_in      = word_ff;
      sym_last_in  = sym_last_ff;
      sym_idx_in   = sym_idx_ff;
      in_pad_in    = in_pad_ff;
      pad_grp_in   = pad_grp_ff;
      pad_idx_in   = pad_idx_ff;
      job_last_in  = job_last_ff;
      lf_pend_in   = lf_pend_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b0;
         if (lf_pend_ff) begin
            rsp_char_in = CHAR_LF;
            lf_pend_in  = 1'b0;
            col_in      = '0;
         end else if (brk_due) begin
            rsp_char_in = CHAR_CR;
            lf_pend_in  = 1'b1;
         end else begin
            rsp_char_in = data_ch;
            rsp_last_in = final_ch;
            if (final_ch && job_last_ff) begin
               col_in = '0;
            end else if (col_ff != COL_MAX) begin
               col_in = col_ff + 7'd1;
            end
            if (final_ch) begin
               job_valid_in = 1'b0;
            end else if (!in_pad_ff) begin
               if (sym_end) begin
                  in_pad_in  = 1'b1;
                  pad_idx_in = 2'd0;
               end else begin
                  sym_idx_in = sym_idx_ff + 2'd1;
               end
            end else if (pad_end) begin
               pad_idx_in = 2'd0;
               pad_grp_in = pad_grp_ff - 2'd1;
            end else begin
               pad_idx_in = pad_idx_ff + 2'd1;
            end
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      // load a finished group
      if (accept && produce) begin
         job_valid_in = 1'b1;
         word_in      = new_word;
         sym_last_in  = new_sym_last;
         sym_idx_in   = 2'd0;
         in_pad_in    = 1'b0;
         pad_grp_in   = new_pad_grp;
         pad_idx_in   = 2'd0;
         job_last_in  = req_ch.last_byte;
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         c62_ff       <= 8'd43;
         c63_ff       <= 8'd47;
         pad_len_ff   <= 2'd1;
         pad1_ff      <= 8'd61;
         pad2_ff      <= 8'd0;
         pad3_ff      <= 8'd0;
         limit_ff     <= '0;
         count_ff     <= 2'd0;
         job_valid_ff <= 1'b0;
         lf_pend_ff   <= 1'b0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         job_valid_ff <= job_valid_in;
         lf_pend_ff   <= lf_pend_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_CHAR_SIXTY_TWO:   c62_ff     <= csr_data;
               REG_CHAR_SIXTY_THREE: c63_ff     <= csr_data;
               REG_PAD_LENGTH:       pad_len_ff <= csr_data[1:0];
               REG_PAD_FIRST:        pad1_ff    <= csr_data;
               REG_PAD_SECOND:       pad2_ff    <= csr_data;
               REG_PAD_THIRD:        pad3_ff    <= csr_data;
               REG_LINE_LIMIT:       limit_ff   <= csr_data[COL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      word_ff     <= word_in;
      sym_last_ff <= sym_last_in;
      sym_idx_ff  <= sym_idx_in;
      in_pad_ff   <= in_pad_in;
      pad_grp_ff  <= pad_grp_in;
      pad_idx_ff  <= pad_idx_in;
      job_last_ff <= job_last_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // a pending LF always belongs to a group still in flight
   `B64SE_ASSERT_SAME(a_lf_in_job, lf_pend_ff, job_valid_ff)
   // a new item only overlaps a group that finishes in the same cycle
   `B64SE_ASSERT_SAME(a_accept_free, accept && job_valid_ff, done)
   // a CR is followed by its LF as soon as the result side moves
   `B64SE_ASSERT_NEXT(a_lf_next, step && lf_pend_ff,
      rsp_valid_ff && (rsp_char_ff == CHAR_LF) && !rsp_last_ff)
   // a last byte always closes the group
   `B64SE_ASSERT_NEXT(a_last_clears, accept && req_ch.last_byte, count_ff == 2'd0)

endmodule
`default_nettype wire
